// ===== sv/lds_pkg.sv =====
// Package for the lax DER signature parser: phases, tags, status codes and sizes.
`default_nettype none

package lds_pkg;

   localparam int VALUE_BYTES = 32;
   localparam int VAL_W       = 256;
   localparam int WORD_W      = 64;
   localparam int NUM_WORDS   = 8;
   localparam int IDX_W       = 3;
   localparam int CNT_W       = $clog2(VALUE_BYTES + 2);
   localparam int LEFT_W      = 7;
   localparam int FLEN_W      = 24;
   localparam int MAX_LEN_BYTES = 4;

   localparam logic [7:0] TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] TAG_INTEGER  = 8'h02;

   localparam logic [1:0] STATUS_REJECT   = 2'd0;
   localparam logic [1:0] STATUS_PARSED   = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef enum logic [3:0] {
      PH_SEQ_TAG  = 4'd0,
      PH_SEQ_LEN  = 4'd1,
      PH_SEQ_SKIP = 4'd2,
      PH_R_TAG    = 4'd3,
      PH_R_LEN    = 4'd4,
      PH_R_LONG   = 4'd5,
      PH_R_VAL    = 4'd6,
      PH_S_TAG    = 4'd7,
      PH_S_LEN    = 4'd8,
      PH_S_LONG   = 4'd9,
      PH_S_VAL    = 4'd10,
      PH_DONE     = 4'd11,
      PH_REJECT   = 4'd12
   } phase_type;

endpackage

`default_nettype wire

// ===== sv/lds_if.sv =====
// Valid/ready channel interfaces for the signature byte input and the word output.
`default_nettype none

interface lds_req_if;
   import lds_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_signature;

   modport source (output valid, in_byte, end_of_signature, input ready);
   modport sink   (input valid, in_byte, end_of_signature, output ready);
endinterface

interface lds_rsp_if;
   import lds_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  word_index;
   logic [WORD_W-1:0] word_value;
   logic [1:0]        parse_status;
   logic              last_word;

   modport source (output valid, word_index, word_value, parse_status, last_word,
                   input ready);
   modport sink   (input valid, word_index, word_value, parse_status, last_word,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/lax_der_signature_parser_top.sv =====
// Lax DER ECDSA signature parser: byte stream in, eight 64-bit words of R and S out.
//
// req_chan carries one signature byte per transaction with end_of_signature on
// the final byte of the buffer. Each byte taken steps the phase machine; value
// bytes after leading zeros, up to 32, are shifted into the R or S register.
// rsp_chan delivers eight transactions per signature, R then S, most significant
// word first, with the same status on each and last_word on the eighth.
// The first word is valid in the cycle after the final byte is taken.
// Throughput: one byte per cycle while req_chan.ready is high; the output buffer
// drains one word per cycle while rsp_chan.ready is high. The next signature's
// bytes are taken while words are still draining; only a final byte is held off
// (req_chan.ready low) while the previous eight words have not all left, so the
// output port paces the signature ends.
// When rsp_chan.ready is low the current word holds and the buffer waits.
// Reset (synchronous, active high) returns the parser to expecting the
// sequence tag, clears R, S and the flags, and empties the output buffer.
`default_nettype none

module lax_der_signature_parser_top
   import lds_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   lds_req_if.sink    req_chan,
   lds_rsp_if.source  rsp_chan
);

   phase_type             phase_ff, phase_in, phase_step;
   logic [LEFT_W-1:0]     left_ff, left_in, left_step;
   logic [FLEN_W-1:0]     flen_ff, flen_in, flen_step;
   logic [CNT_W-1:0]      cnt_ff, cnt_in, cnt_step;
   logic [VAL_W-1:0]      r_ff, r_in, r_step;
   logic [VAL_W-1:0]      s_ff, s_in, s_step;
   logic                  tl_ff, tl_in, tl_step;

   logic [2*VAL_W-1:0]    obuf_ff, obuf_in;
   logic [1:0]            ostat_ff, ostat_in;
   logic [IDX_W-1:0]      oidx_ff, oidx_in;
   logic                  busy_ff, busy_in;

   logic                  take, take_last, rsp_take, drain_done, is_s;
   logic [7:0]            b;
   logic [FLEN_W-1:0]     flen_long;
   logic [CNT_W-1:0]      cnt_sat;
   logic [1:0]            status_now;
   phase_type             phase_empty, phase_val;

   assign b          = req_chan.in_byte;
   assign rsp_take   = rsp_chan.valid && rsp_chan.ready;
   assign drain_done = rsp_take && (oidx_ff == IDX_W'(NUM_WORDS - 1));
   assign req_chan.ready = !busy_ff || !req_chan.end_of_signature || drain_done;
   assign take       = req_chan.valid && req_chan.ready;
   assign take_last  = take && req_chan.end_of_signature;

   assign is_s = (phase_ff == PH_S_LEN) || (phase_ff == PH_S_LONG) ||
                 (phase_ff == PH_S_VAL);
   assign phase_empty = is_s ? PH_DONE : PH_S_TAG;
   assign phase_val   = is_s ? PH_S_VAL : PH_R_VAL;
   assign flen_long   = {flen_ff[FLEN_W-9:0], b};
   assign cnt_sat     = (cnt_ff <= CNT_W'(VALUE_BYTES)) ? cnt_ff + 1'b1 : cnt_ff;

   // one byte through the phase machine
   always_comb begin
      phase_step = phase_ff;
      left_step  = left_ff;
      flen_step  = flen_ff;
      cnt_step   = cnt_ff;
      r_step     = r_ff;
      s_step     = s_ff;
      tl_step    = tl_ff;
      if (take) begin
         unique case (phase_ff) inside
            PH_SEQ_TAG: begin
               phase_step = (b == TAG_SEQUENCE) ? PH_SEQ_LEN : PH_REJECT;
            end
            PH_SEQ_LEN: begin
               if (b[7]) begin
                  left_step  = b[6:0];
                  phase_step = (b[6:0] == '0) ? PH_R_TAG : PH_SEQ_SKIP;
               end else begin
                  phase_step = PH_R_TAG;
               end
            end
            PH_SEQ_SKIP: begin
               left_step = left_ff - 1'b1;
               if (left_ff == LEFT_W'(1)) phase_step = PH_R_TAG;
            end
            PH_R_TAG: begin
               phase_step = (b == TAG_INTEGER) ? PH_R_LEN : PH_REJECT;
            end
            PH_S_TAG: begin
               phase_step = (b == TAG_INTEGER) ? PH_S_LEN : PH_REJECT;
            end
            PH_R_LEN, PH_S_LEN: begin
               cnt_step = '0;
               if (b[7]) begin
                  flen_step = '0;
                  if (b[6:0] == '0) begin
                     left_step  = '0;
                     phase_step = phase_empty;
                  end else begin
                     left_step  = b[6:0];
                     phase_step = is_s ? PH_S_LONG : PH_R_LONG;
                  end
               end else begin
                  flen_step  = FLEN_W'(b);
                  left_step  = '0;
                  phase_step = (b == '0) ? phase_empty : phase_val;
               end
            end
            PH_R_LONG, PH_S_LONG: begin
               if ((flen_ff == '0) && (b != '0) &&
                   (left_ff >= LEFT_W'(MAX_LEN_BYTES))) begin
                  phase_step = PH_REJECT;
               end else begin
                  if (!((flen_ff == '0) && (b == '0))) flen_step = flen_long;
                  left_step = left_ff - 1'b1;
                  if (left_ff == LEFT_W'(1)) begin
                     cnt_step   = '0;
                     left_step  = '0;
                     phase_step = (flen_step == '0) ? phase_empty : phase_val;
                  end
               end
            end
            PH_R_VAL, PH_S_VAL: begin
               if (!((cnt_ff == '0) && (b == '0))) begin
                  cnt_step = cnt_sat;
                  if (cnt_sat > CNT_W'(VALUE_BYTES)) begin
                     tl_step = 1'b1;
                  end else if (is_s) begin
                     s_step = {s_ff[VAL_W-9:0], b};
                  end else begin
                     r_step = {r_ff[VAL_W-9:0], b};
                  end
               end
               flen_step = flen_ff - 1'b1;
               if (flen_ff == FLEN_W'(1)) phase_step = phase_empty;
            end
            default: begin
            end
         endcase
      end
   end

   assign status_now = (phase_step != PH_DONE) ? STATUS_REJECT :
                       tl_step ? STATUS_TOO_LONG : STATUS_PARSED;

   // parser state clears after the final byte
   always_comb begin
      if (take_last) begin
         phase_in = PH_SEQ_TAG;
         left_in  = '0;
         flen_in  = '0;
         cnt_in   = '0;
         r_in     = '0;
         s_in     = '0;
         tl_in    = 1'b0;
      end else begin
         phase_in = phase_step;
         left_in  = left_step;
         flen_in  = flen_step;
         cnt_in   = cnt_step;
         r_in     = r_step;
         s_in     = s_step;
         tl_in    = tl_step;
      end
   end

   // output buffer: loads on the final byte, shifts one word per transaction
   always_comb begin
      obuf_in  = obuf_ff;
      ostat_in = ostat_ff;
      oidx_in  = oidx_ff;
      busy_in  = busy_ff;
      if (rsp_take) begin
         obuf_in = {obuf_ff[2*VAL_W-WORD_W-1:0], WORD_W'(0)};
         oidx_in = oidx_ff + 1'b1;
         if (drain_done) busy_in = 1'b0;
      end
      if (take_last) begin
         obuf_in  = (status_now == STATUS_PARSED) ? {r_step, s_step} : '0;
         ostat_in = status_now;
         oidx_in  = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEQ_TAG;
         left_ff  <= '0;
         flen_ff  <= '0;
         cnt_ff   <= '0;
         r_ff     <= '0;
         s_ff     <= '0;
         tl_ff    <= 1'b0;
         oidx_ff  <= '0;
         busy_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         flen_ff  <= flen_in;
         cnt_ff   <= cnt_in;
         r_ff     <= r_in;
         s_ff     <= s_in;
         tl_ff    <= tl_in;
         oidx_ff  <= oidx_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      obuf_ff  <= obuf_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_chan.valid        = busy_ff;
   assign rsp_chan.word_index   = oidx_ff;
   assign rsp_chan.word_value   = obuf_ff[2*VAL_W-1 -: WORD_W];
   assign rsp_chan.parse_status = ostat_ff;
   assign rsp_chan.last_word    = (oidx_ff == IDX_W'(NUM_WORDS - 1));

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      take_last |=> (rsp_chan.valid && (rsp_chan.word_index == '0)))
      else $error("run did not start at word 0 after final byte");

   a_parser_cleared: assert property (@(posedge clock) disable iff (reset)
      take_last |=> (phase_ff == PH_SEQ_TAG && !tl_ff && cnt_ff == '0))
      else $error("parser not cleared after final byte");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (ostat_ff == STATUS_REJECT || ostat_ff == STATUS_PARSED ||
                          ostat_ff == STATUS_TOO_LONG))
      else $error("invalid status code");

   a_zero_unless_parsed: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && ostat_ff != STATUS_PARSED) |-> (rsp_chan.word_value == '0))
      else $error("nonzero word on failed parse");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !drain_done) |-> !take_last)
      else $error("final byte taken while buffer still full");

endmodule

`default_nettype wire
